>>> design/rbf_pkg.sv
// Shared constants, state type and helpers of the brightness fade block.
package rbf_pkg;

	// Fixed field widths
	localparam int LENGTH_BITS = 12;
	localparam int LEVEL_W     = 8;
	localparam int NUM_CH      = 3;
	localparam int CH_W        = 2;

	// Scaled values (frames * 100) need seven more bits than a frame count
	localparam int DIV_W = LENGTH_BITS + 7;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = '1;
	localparam logic [CH_W-1:0]    CH_LAST     = CH_W'(NUM_CH - 1);

	// Division modes of the shared serial divider
	typedef enum logic {
		MODE_SLOPE,
		MODE_STEP
	} div_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_FIN,
		S_CHECK,
		S_DONE
	} fade_state_t;

	// Multiply a frame count by 100 (64 + 32 + 4)
	function automatic logic [DIV_W-1:0] times100(input logic [LENGTH_BITS-1:0] n);
		logic [DIV_W-1:0] w;
		w = DIV_W'(n);
		return (w << 6) + (w << 5) + (w << 2);
	endfunction

endpackage

>>> design/rgb_brightness_fade.sv
// Top level of the linear red/green/blue brightness fade.
//
//  channel | valid     | stall     | words carried
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | target_red/green/blue, fade_length
//  out     | out_valid | out_stall | bright_red/green/blue, frames_left, applied
//
// One word is worked at a time by a bit-serial restoring divider shared by the
// three channels, one quotient bit per cycle.
// A tick inside a fade runs a step divide per channel with a nonzero slope, and
// a tick that restarts the fade first runs a slope divide per channel. The last
// frame snaps to the target; a tick after the fade has ended does no division.
// Reset sets all levels to full scale and forces a restart on the first tick.
// A finished word waits in the output register while the next word is taken.
module rgb_brightness_fade (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_red,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_green,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_blue,
	input  logic [rbf_pkg::LENGTH_BITS-1:0]   fade_length,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rbf_pkg::LEVEL_W-1:0]       bright_red,
	output logic [rbf_pkg::LEVEL_W-1:0]       bright_green,
	output logic [rbf_pkg::LEVEL_W-1:0]       bright_blue,
	output logic [rbf_pkg::LENGTH_BITS-1:0]   frames_left,
	output logic                              applied
);
	import rbf_pkg::*;

	fade_state_t state_q, state_d;

	// Fade state
	logic [LEVEL_W-1:0]     cur_q   [NUM_CH];
	logic [LEVEL_W-1:0]     start_q [NUM_CH];
	logic [LEVEL_W-1:0]     tgt_q   [NUM_CH];
	logic [DIV_W-1:0]       dmag_q  [NUM_CH];
	logic [NUM_CH-1:0]      dneg_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic                   armed_q;

	// Serial divider and sequencing
	div_mode_t              mode_q;
	logic [CH_W-1:0]        ch_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIV_W-1:0]       dvd_q;
	logic [DIV_W-1:0]       den_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       quo_q;
	logic                   zero_q;
	logic                   upd_q;

	// Output register
	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     out_lvl_q [NUM_CH];
	logic [LENGTH_BITS-1:0] out_left_q;
	logic                   out_applied_q;

	logic                   in_take;
	logic                   out_take;
	logic                   out_free;
	logic                   restart;
	logic                   div_last;
	logic                   ch_last;
	logic                   fade_over;
	logic                   final_frame;
	logic                   step_zero;
	logic [DIV_W:0]         trial;
	logic [DIV_W:0]         diff;
	logic                   fits;
	logic [LEVEL_W:0]       delta;
	logic [LEVEL_W-1:0]     delta_mag;
	logic [DIV_W:0]         up_sum;
	logic [LEVEL_W-1:0]     up_lvl;
	logic [LEVEL_W-1:0]     dn_lvl;
	logic [LEVEL_W-1:0]     new_lvl;

	assign in_take  = in_valid & ~in_stall;
	assign out_take = out_valid_q & ~out_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// Detect a changed target or length
	assign restart = ~armed_q || (fade_length != len_q) || (target_red != tgt_q[0])
		|| (target_green != tgt_q[1]) || (target_blue != tgt_q[2]);

	assign div_last    = (cnt_q == CNT_W'(1));
	assign ch_last     = (ch_q == CH_LAST);
	assign fade_over   = (count_q >= len_q);
	assign final_frame = (LENGTH_BITS'(count_q + 1'b1) == len_q);
	assign step_zero   = (dmag_q[ch_q] == '0);

	// One restoring divide step
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	// Signed change of the current channel for the slope divide
	assign delta     = {1'b0, tgt_q[ch_q]} - {1'b0, start_q[ch_q]};
	assign delta_mag = delta[LEVEL_W] ? LEVEL_W'(-delta) : delta[LEVEL_W-1:0];

	// Apply the signed quotient to the start level and saturate
	assign up_sum  = {1'b0, quo_q} + (DIV_W + 1)'(start_q[ch_q]);
	assign up_lvl  = (up_sum > (DIV_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX : up_sum[LEVEL_W-1:0];
	assign dn_lvl  = (quo_q > DIV_W'(start_q[ch_q])) ? '0
		: LEVEL_W'(start_q[ch_q] - quo_q[LEVEL_W-1:0]);
	assign new_lvl = dneg_q[ch_q] ? dn_lvl : up_lvl;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pick the next state
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = restart ? S_LOAD : S_CHECK;
				end
			end
			S_LOAD: begin
				if (mode_q == MODE_STEP && step_zero) begin
					state_d = ch_last ? S_DONE : S_LOAD;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!ch_last) begin
					state_d = S_LOAD;
				end else begin
					state_d = (mode_q == MODE_SLOPE) ? S_CHECK : S_DONE;
				end
			end
			S_CHECK: begin
				state_d = (fade_over || final_frame) ? S_DONE : S_LOAD;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the fade and the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				cur_q[c]   <= LEVEL_RESET;
				start_q[c] <= '0;
				tgt_q[c]   <= '0;
				dmag_q[c]  <= '0;
			end
			dneg_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			armed_q <= 1'b0;
			mode_q  <= MODE_SLOPE;
			ch_q    <= '0;
			cnt_q   <= '0;
			upd_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// Capture a new fade on restart
					if (in_take && restart) begin
						tgt_q[0] <= target_red;
						tgt_q[1] <= target_green;
						tgt_q[2] <= target_blue;
						for (int c = 0; c < NUM_CH; c++) begin
							start_q[c] <= cur_q[c];
						end
						len_q   <= fade_length;
						count_q <= '0;
						armed_q <= 1'b1;
						mode_q  <= MODE_SLOPE;
						ch_q    <= '0;
					end
				end
				S_LOAD: begin
					cnt_q <= CNT_W'(DIV_W);
					if (mode_q == MODE_STEP && step_zero) begin
						// No slope: hold the start level
						cur_q[ch_q] <= start_q[ch_q];
						if (ch_last) begin
							count_q <= LENGTH_BITS'(count_q + 1'b1);
							upd_q   <= 1'b1;
						end else begin
							ch_q <= CH_W'(ch_q + 1'b1);
						end
					end
				end
				S_DIV: begin
					cnt_q <= CNT_W'(cnt_q - 1'b1);
				end
				S_FIN: begin
					if (mode_q == MODE_SLOPE) begin
						dmag_q[ch_q] <= zero_q ? '0 : quo_q;
						dneg_q[ch_q] <= delta[LEVEL_W];
					end else begin
						cur_q[ch_q] <= new_lvl;
					end
					if (ch_last) begin
						ch_q <= '0;
						if (mode_q == MODE_STEP) begin
							count_q <= LENGTH_BITS'(count_q + 1'b1);
							upd_q   <= 1'b1;
						end
					end else begin
						ch_q <= CH_W'(ch_q + 1'b1);
					end
				end
				S_CHECK: begin
					if (fade_over) begin
						upd_q <= 1'b0;
					end else if (final_frame) begin
						// Snap to the target on the last frame
						for (int c = 0; c < NUM_CH; c++) begin
							cur_q[c] <= tgt_q[c];
						end
						count_q <= LENGTH_BITS'(count_q + 1'b1);
						upd_q   <= 1'b1;
					end else begin
						mode_q <= MODE_STEP;
						ch_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Load and shift the divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			rem_q <= '0;
			quo_q <= '0;
			if (mode_q == MODE_SLOPE) begin
				dvd_q  <= times100(len_q);
				den_q  <= DIV_W'(delta_mag);
				zero_q <= (delta_mag == '0);
			end else begin
				dvd_q  <= times100(count_q);
				den_q  <= dmag_q[ch_q];
				zero_q <= 1'b0;
			end
		end else if (state_q == S_DIV) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			for (int c = 0; c < NUM_CH; c++) begin
				out_lvl_q[c] <= cur_q[c];
			end
			out_left_q    <= upd_q ? LENGTH_BITS'(len_q - count_q) : '0;
			out_applied_q <= upd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bright_red   = out_lvl_q[0];
	assign bright_green = out_lvl_q[1];
	assign bright_blue  = out_lvl_q[2];
	assign frames_left  = out_left_q;
	assign applied      = out_applied_q;

endmodule

>>> design/rbf_checker.sv
// Port checker of the brightness fade, bound to the top level.
module rbf_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_red,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_green,
	input  logic [rbf_pkg::LEVEL_W-1:0]       target_blue,
	input  logic [rbf_pkg::LENGTH_BITS-1:0]   fade_length,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [rbf_pkg::LEVEL_W-1:0]       bright_red,
	input  logic [rbf_pkg::LEVEL_W-1:0]       bright_green,
	input  logic [rbf_pkg::LEVEL_W-1:0]       bright_blue,
	input  logic [rbf_pkg::LENGTH_BITS-1:0]   frames_left,
	input  logic                              applied
);
	import rbf_pkg::*;

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bright_red)
		&& $stable(bright_green) && $stable(bright_blue)
		&& $stable(frames_left) && $stable(applied))
		else $error("stalled output word changed");

	// A finished fade reports no frames left
	a_done_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !applied |-> frames_left == '0)
		else $error("finished fade reports frames left");

	// One word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	// A new output word only comes out of work in progress
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word without work in progress");

endmodule

bind rgb_brightness_fade rbf_checker u_rbf_checker (.*);

>>> verif/rgb_brightness_fade_tb.sv
// Self-checking testbench of the red/green/blue brightness fade block.
`timescale 1ns / 1ps

module rgb_brightness_fade_tb;
	import rbf_pkg::*;

	typedef struct packed {
		logic [LEVEL_W-1:0]     red;
		logic [LEVEL_W-1:0]     green;
		logic [LEVEL_W-1:0]     blue;
		logic [LENGTH_BITS-1:0] left;
		logic                   applied;
	} fade_word_t;

	typedef enum int {
		PH_FREE,
		PH_SENDER_IDLE,
		PH_RECEIVER_STALL,
		PH_BOTH
	} idle_phase_t;

	localparam int SCALE        = 100;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_WORDS  = 470;
	localparam int SETTLE_TICKS = 150;

	// Fade predictor and the queue of brightness words it expects
	class fade_scoreboard;
		logic [LEVEL_W-1:0]     level [NUM_CH];
		logic [LEVEL_W-1:0]     origin [NUM_CH];
		logic [LEVEL_W-1:0]     aim [NUM_CH];
		int                     divisor [NUM_CH];
		logic [LENGTH_BITS-1:0] span;
		logic [LENGTH_BITS-1:0] count;
		bit                     armed;
		fade_word_t             pending_q[$];
		int words_checked, mismatches, restarts, finished_ticks, clamps, flat_channels;

		function new();
			for (int c = 0; c < NUM_CH; c++) begin
				level[c]   = LEVEL_RESET;
				origin[c]  = '0;
				aim[c]     = '0;
				divisor[c] = 0;
			end
			span  = '0;
			count = '0;
			armed = 1'b0;
		endfunction

		// Advance the fade by one frame tick and queue the word it yields
		function void note_input(logic [LEVEL_W-1:0] tr, logic [LEVEL_W-1:0] tg,
				logic [LEVEL_W-1:0] tb, logic [LENGTH_BITS-1:0] len);
			logic [LEVEL_W-1:0] t [NUM_CH];
			bit                 restart;
			int                 delta, q, v, frames;
			fade_word_t         w;
			t[0] = tr;
			t[1] = tg;
			t[2] = tb;
			frames = int'(len);
			restart = !armed || len != span;
			for (int c = 0; c < NUM_CH; c++)
				if (t[c] != aim[c])
					restart = 1'b1;

			// Capture the start levels and one slope divisor per channel
			if (restart) begin
				restarts++;
				for (int c = 0; c < NUM_CH; c++) begin
					delta      = int'(t[c]) - int'(level[c]);
					origin[c]  = level[c];
					aim[c]     = t[c];
					divisor[c] = (delta == 0) ? 0 : (frames * SCALE) / delta;
					if (divisor[c] == 0 && delta != 0)
						flat_channels++;
				end
				span  = len;
				count = '0;
				armed = 1'b1;
			end

			if (count >= span) begin
				finished_ticks++;
				w.red     = level[0];
				w.green   = level[1];
				w.blue    = level[2];
				w.left    = '0;
				w.applied = 1'b0;
			end else begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (int'(count) + 1 == int'(span)) begin
						level[c] = aim[c];
					end else if (divisor[c] != 0) begin
						q = (int'(count) * SCALE) / divisor[c];
						v = int'(origin[c]) + q;
						if (v < 0 || v > int'(LEVEL_MAX))
							clamps++;
						level[c] = (v < 0) ? '0 : (v > int'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
					end else begin
						level[c] = origin[c];
					end
				end
				count     = count + 1'b1;
				w.red     = level[0];
				w.green   = level[1];
				w.blue    = level[2];
				w.left    = span - count;
				w.applied = 1'b1;
			end
			pending_q.push_back(w);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%t: %s", $realtime, msg);
		endfunction

		// Compare one output word with the oldest expected one
		function void check_result(fade_word_t got);
			fade_word_t want;
			words_checked++;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected word rgb=%0d/%0d/%0d left=%0d applied=%0d",
					got.red, got.green, got.blue, got.left, got.applied));
				return;
			end
			want = pending_q.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
					got.left !== want.left || got.applied !== want.applied)
				report($sformatf({"word mismatch: expected rgb=%0d/%0d/%0d left=%0d ",
					"applied=%0d, got rgb=%0d/%0d/%0d left=%0d applied=%0d"},
					want.red, want.green, want.blue, want.left, want.applied,
					got.red, got.green, got.blue, got.left, got.applied));
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [LEVEL_W-1:0]     target_red;
	logic [LEVEL_W-1:0]     target_green;
	logic [LEVEL_W-1:0]     target_blue;
	logic [LENGTH_BITS-1:0] fade_length;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [LEVEL_W-1:0]     bright_red;
	logic [LEVEL_W-1:0]     bright_green;
	logic [LEVEL_W-1:0]     bright_blue;
	logic [LENGTH_BITS-1:0] frames_left;
	logic                   applied;

	fade_scoreboard sb = new();
	int idle_pct  = 0;
	int stall_pct = 0;
	int sent      = 0;

	rgb_brightness_fade dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_red   (target_red),
		.target_green (target_green),
		.target_blue  (target_blue),
		.fade_length  (fade_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bright_red   (bright_red),
		.bright_green (bright_green),
		.bright_blue  (bright_blue),
		.frames_left  (frames_left),
		.applied      (applied)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the output channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Check every accepted output word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{bright_red, bright_green, bright_blue, frames_left, applied});
	end

	// Offer one tick word after an optional gap; return on the falling edge after acceptance
	task automatic send_word(input logic [LEVEL_W-1:0] tr, input logic [LEVEL_W-1:0] tg,
			input logic [LEVEL_W-1:0] tb, input logic [LENGTH_BITS-1:0] len);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (idle_pct != 0 && $urandom_range(0, 9) == 0)
			gap += $urandom_range(1, 150);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		target_red   <= tr;
		target_green <= tg;
		target_blue  <= tb;
		fade_length  <= len;
		do @(posedge clk); while (in_stall);
		sb.note_input(tr, tg, tb, len);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic [LEVEL_W-1:0] tr, input logic [LEVEL_W-1:0] tg,
			input logic [LEVEL_W-1:0] tb, input logic [LENGTH_BITS-1:0] len, input int n);
		repeat (n) send_word(tr, tg, tb, len);
	endtask

	// Hold the sender off until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level(int c);
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return sb.level[c];
		if (r < 30)
			return '0;
		if (r < 40)
			return LEVEL_MAX;
		return LEVEL_W'($urandom());
	endfunction

	// Mostly short fades, a few zero lengths and some long ones
	function automatic logic [LENGTH_BITS-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 80)
			return LENGTH_BITS'($urandom_range(1, 12));
		if (r < 95)
			return LENGTH_BITS'($urandom_range(13, 60));
		return LENGTH_BITS'($urandom());
	endfunction

	// Random fades: full runs, runs cut short or retuned, and stray words
	task automatic run_fades(input int quota);
		logic [LEVEL_W-1:0]     aim [NUM_CH];
		logic [LENGTH_BITS-1:0] len;
		int                     kind, ticks;
		while (sent < quota) begin
			kind = $urandom_range(0, 99);
			for (int c = 0; c < NUM_CH; c++)
				aim[c] = pick_level(c);
			len = pick_length();
			if (kind < 15) begin
				send_word(LEVEL_W'($urandom()), LEVEL_W'($urandom()), LEVEL_W'($urandom()),
					pick_length());
			end else begin
				ticks = (len <= 60) ? int'(len) + $urandom_range(1, 3) : $urandom_range(2, 6);
				if (kind < 30)
					ticks = $urandom_range(1, ticks);
				send_run(aim[0], aim[1], aim[2], len, ticks);
				if (kind < 30 && $urandom_range(0, 1) == 1)
					send_word(aim[0], aim[1], aim[2],
						len ^ (LENGTH_BITS'(1) << $urandom_range(0, LENGTH_BITS - 1)));
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		target_red   = '0;
		target_green = '0;
		target_blue  = '0;
		fade_length  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: fall from full scale with undershoot, rise back with overshoot
		send_run(8'd0, 8'd0, 8'd0, 12'd5, 6);
		send_run(8'd255, 8'd255, 8'd255, 12'd5, 5);
		// Zero length, then no change on red and a length too short for green
		send_run(8'd255, 8'd128, 8'd0, 12'd0, 2);
		send_run(8'd255, 8'd0, 8'd200, 12'd2, 3);
		// Longest length and alternating bit patterns
		send_run(8'd0, 8'd255, 8'd1, 12'd4095, 2);
		send_word(8'd170, 8'd85, 8'd170, 12'd2730);
		send_word(8'd85, 8'd170, 8'd85, 12'd1365);
		// Single-frame fade snaps at once, then finishes
		send_run(8'd0, 8'd0, 8'd0, 12'd1, 2);
		drain();

		// Random fades under each idling pattern
		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			case (idle_phase_t'(p))
				PH_FREE: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				PH_SENDER_IDLE: begin
					idle_pct  = 73;
					stall_pct = 0;
				end
				PH_RECEIVER_STALL: begin
					idle_pct  = 0;
					stall_pct = 73;
				end
				default: begin
					idle_pct  = 15;
					stall_pct = 15;
				end
			endcase
			run_fades(sent + PHASE_WORDS);
			drain();
		end

		repeat (SETTLE_TICKS) @(negedge clk);
		$display("covered %0d tick words, %0d results: %0d fade restarts, %0d ticks past the end",
			sent, sb.words_checked, sb.restarts, sb.finished_ticks);
		$display("%0d clamped levels, %0d channels with a zero slope divisor, %0d mismatches",
			sb.clamps, sb.flat_channels, sb.mismatches);
		if (sb.pending() != 0)
			$display("%0d expected words never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("rgb_brightness_fade_tb OK");
		end else begin
			$display("rgb_brightness_fade_tb NOT OK");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("timeout with %0d words outstanding", sb.pending());
		$display("rgb_brightness_fade_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/rbf_pkg.sv
design/rgb_brightness_fade.sv
design/rbf_checker.sv
verif/rgb_brightness_fade_tb.sv
